// ===== hw/rtl/phtc_pkg.sv =====
package phtc_pkg;

  localparam int TABLE_SLOTS_DEF = 64;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [6:0]  ETH_HDR_BYTES  = 7'd14;

  localparam logic [2:0] ST_COUNTED    = 3'd0;
  localparam logic [2:0] ST_IGNORED    = 3'd1;
  localparam logic [2:0] ST_FULL       = 3'd2;
  localparam logic [2:0] ST_READ_VALID = 3'd3;
  localparam logic [2:0] ST_READ_EMPTY = 3'd4;

  localparam logic FUNC_COUNT = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  typedef struct packed {
    logic [31:0] tx_pkts;
    logic [31:0] rx_pkts;
    logic [31:0] tx_octets;
    logic [31:0] rx_octets;
  } cnt_t;

  typedef struct packed {
    logic rd;
    logic wr_cnt;
    logic wr_addr;
  } mem_req_t;

endpackage

// ===== hw/rtl/phtc_channels.sv =====
interface phtc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] frame_type;
  logic [31:0] source_address;
  logic [31:0] destination_address;
  logic [3:0]  header_words;
  logic [15:0] frame_length;
  logic [5:0]  read_slot;

  modport source (
    output valid, func, frame_type, source_address, destination_address,
           header_words, frame_length, read_slot,
    input  ready
  );
  modport sink (
    input  valid, func, frame_type, source_address, destination_address,
           header_words, frame_length, read_slot,
    output ready
  );
endinterface

interface phtc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] slot_address_out;
  logic [31:0] tx_packets_out;
  logic [31:0] rx_packets_out;
  logic [31:0] tx_octets_out;
  logic [31:0] rx_octets_out;
  logic [6:0]  slots_in_use;

  modport source (
    output valid, status, slot_address_out, tx_packets_out, rx_packets_out,
           tx_octets_out, rx_octets_out, slots_in_use,
    input  ready
  );
  modport sink (
    input  valid, status, slot_address_out, tx_packets_out, rx_packets_out,
           tx_octets_out, rx_octets_out, slots_in_use,
    output ready
  );
endinterface

// ===== hw/rtl/phtc_mem.sv =====
module phtc_mem
  import phtc_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
  input  logic              clk,
  input  mem_req_t          req,
  input  logic [SLOT_W-1:0] rd_idx,
  input  logic [SLOT_W-1:0] wr_idx,
  input  logic [31:0]       wr_addr,
  input  cnt_t              wr_cnt,
  output logic [31:0]       rd_addr,
  output cnt_t              rd_cnt
);

  logic [31:0] addr_mem [TABLE_SLOTS];
  cnt_t        cnt_mem  [TABLE_SLOTS];

  always_ff @(posedge clk) begin
    if (req.wr_addr) begin
      addr_mem[wr_idx] <= wr_addr;
    end
    if (req.rd) begin
      rd_addr <= addr_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_cnt) begin
      cnt_mem[wr_idx] <= wr_cnt;
    end
    if (req.rd) begin
      rd_cnt <= cnt_mem[rd_idx];
    end
  end

endmodule

// ===== hw/rtl/per_host_traffic_counter_table_top.sv =====
// Request accepted to result valid: a read of an occupied slot does one table read,
// a non-IPv4 frame none, an IPv4 count one address memory read per occupied slot.
// Throughput: one request at a time; the next request is taken once the result is
// registered, while that result still waits on out_ch.ready.
// Reset (synchronous, rst_n low): table empty, no result pending; memory contents
// are not cleared, occupancy comes from the fill count.
module per_host_traffic_counter_table_top
  import phtc_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  phtc_in_if.sink   in_ch,
  phtc_out_if.source out_ch
);

  localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
  localparam int CMP_W  = ((CNT_W > 6) ? CNT_W : 6) + 1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SCAN = 8'b0000_0010,
    S_SRD  = 8'b0000_0100,
    S_SWR  = 8'b0000_1000,
    S_DRD  = 8'b0001_0000,
    S_DWR  = 8'b0010_0000,
    S_RDW  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0]       src_r, dst_r;
  logic [3:0]        hw_r;
  logic [15:0]       flen_r;
  logic [CNT_W-1:0]  used_r;
  logic [CNT_W-1:0]  issue_r;
  logic              pend_r;
  logic [SLOT_W-1:0] pend_idx_r;
  logic              s_hit_r, d_hit_r;
  logic [SLOT_W-1:0] s_slot_r, d_slot_r;
  logic              s_new_r, d_new_r, d_ok_r;
  logic [2:0]        res_status_r;
  logic [31:0]       res_addr_r;
  cnt_t              res_cnt_r;

  logic              out_valid_r;
  logic [2:0]        out_status_r;
  logic [31:0]       out_addr_r;
  cnt_t              out_cnt_r;
  logic [6:0]        out_used_r;

  mem_req_t          mreq;
  logic [SLOT_W-1:0] rd_idx, wr_idx;
  logic [31:0]       wr_addr, rd_addr;
  cnt_t              wr_cnt, rd_cnt, base_cnt;

  logic              in_acc;
  logic [CMP_W-1:0]  rslot_ext, used_ext;
  logic              rd_hit;
  logic              scan_issue, scan_done;
  logic [6:0]        ovh;
  logic [15:0]       pay;
  logic [CNT_W+6:0]  used_wide;
  logic              out_load;

  logic              s_ok_n, s_new_n, d_ok_n, d_new_n;
  logic [SLOT_W-1:0] s_slot_n, d_slot_n;
  logic [CNT_W-1:0]  used1, used_fin;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign rslot_ext = {{(CMP_W-6){1'b0}}, in_ch.read_slot};
  assign used_ext  = {{(CMP_W-CNT_W){1'b0}}, used_r};
  assign rd_hit    = rslot_ext < used_ext;

  assign scan_issue = (state_r == S_SCAN) && (issue_r < used_r);
  assign scan_done  = (state_r == S_SCAN) && !scan_issue && !pend_r;

  assign ovh = ETH_HDR_BYTES + {1'b0, hw_r, 2'b00};
  assign pay = (flen_r > {9'd0, ovh}) ? (flen_r - {9'd0, ovh}) : 16'd0;

  assign used_wide = {7'd0, used_r};
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  // resolve slots once the scan is over; source allocates before destination
  always_comb begin
    s_ok_n   = 1'b0;
    s_new_n  = 1'b0;
    s_slot_n = s_slot_r;
    d_ok_n   = 1'b0;
    d_new_n  = 1'b0;
    d_slot_n = d_slot_r;
    used1    = used_r;
    used_fin = used_r;
    if (s_hit_r) begin
      s_ok_n = 1'b1;
    end else if (used_r < CNT_W'(TABLE_SLOTS)) begin
      s_ok_n   = 1'b1;
      s_new_n  = 1'b1;
      s_slot_n = used_r[SLOT_W-1:0];
      used1    = used_r + CNT_W'(1);
    end
    used_fin = used1;
    if (d_hit_r) begin
      d_ok_n = 1'b1;
    end else if (dst_r == src_r) begin
      d_ok_n   = s_ok_n;
      d_slot_n = s_slot_n;
    end else if (used1 < CNT_W'(TABLE_SLOTS)) begin
      d_ok_n   = 1'b1;
      d_new_n  = 1'b1;
      d_slot_n = used1[SLOT_W-1:0];
      used_fin = used1 + CNT_W'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.func == FUNC_READ) begin
            state_nxt = rd_hit ? S_RDW : S_OUT;
          end else if (in_ch.frame_type != ETHERTYPE_IPV4) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_nxt = s_ok_n ? S_SRD : (d_ok_n ? S_DRD : S_OUT);
        end
      end
      S_SRD:   state_nxt = S_SWR;
      S_SWR:   state_nxt = d_ok_r ? S_DRD : S_OUT;
      S_DRD:   state_nxt = S_DWR;
      S_DWR:   state_nxt = S_OUT;
      S_RDW:   state_nxt = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    mreq     = '0;
    rd_idx   = issue_r[SLOT_W-1:0];
    wr_idx   = s_slot_r;
    wr_addr  = src_r;
    base_cnt = '0;
    wr_cnt   = '0;
    case (state_r)
      S_IDLE: begin
        mreq.rd = in_acc && (in_ch.func == FUNC_READ) && rd_hit;
        rd_idx  = rslot_ext[SLOT_W-1:0];
      end
      S_SCAN: begin
        mreq.rd = scan_issue;
      end
      S_SRD: begin
        mreq.rd = 1'b1;
        rd_idx  = s_slot_r;
      end
      S_DRD: begin
        mreq.rd = 1'b1;
        rd_idx  = d_slot_r;
      end
      S_SWR: begin
        base_cnt         = s_new_r ? '0 : rd_cnt;
        wr_cnt           = base_cnt;
        wr_cnt.tx_pkts   = base_cnt.tx_pkts + 32'd1;
        wr_cnt.tx_octets = base_cnt.tx_octets + {16'd0, pay};
        mreq.wr_cnt      = 1'b1;
        mreq.wr_addr     = s_new_r;
      end
      S_DWR: begin
        base_cnt         = d_new_r ? '0 : rd_cnt;
        wr_cnt           = base_cnt;
        wr_cnt.rx_pkts   = base_cnt.rx_pkts + 32'd1;
        wr_cnt.rx_octets = base_cnt.rx_octets + {16'd0, pay};
        mreq.wr_cnt      = 1'b1;
        mreq.wr_addr     = d_new_r;
        wr_idx           = d_slot_r;
        wr_addr          = dst_r;
      end
      default: begin
        mreq = '0;
      end
    endcase
  end

  phtc_mem #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_mem (
    .clk     (clk),
    .req     (mreq),
    .rd_idx  (rd_idx),
    .wr_idx  (wr_idx),
    .wr_addr (wr_addr),
    .wr_cnt  (wr_cnt),
    .rd_addr (rd_addr),
    .rd_cnt  (rd_cnt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      issue_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        issue_r <= '0;
        pend_r  <= 1'b0;
      end else if (state_r == S_SCAN) begin
        pend_r <= scan_issue;
        if (scan_issue) begin
          issue_r <= issue_r + CNT_W'(1);
        end
      end
      if (scan_done) begin
        used_r <= used_fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      src_r   <= in_ch.source_address;
      dst_r   <= in_ch.destination_address;
      hw_r    <= in_ch.header_words;
      flen_r  <= in_ch.frame_length;
      s_hit_r <= 1'b0;
      d_hit_r <= 1'b0;
      res_addr_r <= '0;
      res_cnt_r  <= '0;
      if (in_ch.func == FUNC_READ) begin
        res_status_r <= rd_hit ? ST_READ_VALID : ST_READ_EMPTY;
      end else if (in_ch.frame_type != ETHERTYPE_IPV4) begin
        res_status_r <= ST_IGNORED;
      end else begin
        res_status_r <= ST_COUNTED;
      end
    end
    if (scan_issue) begin
      pend_idx_r <= issue_r[SLOT_W-1:0];
    end
    if ((state_r == S_SCAN) && pend_r) begin
      if (rd_addr == src_r) begin
        s_hit_r  <= 1'b1;
        s_slot_r <= pend_idx_r;
      end
      if (rd_addr == dst_r) begin
        d_hit_r  <= 1'b1;
        d_slot_r <= pend_idx_r;
      end
    end
    if (scan_done) begin
      s_new_r  <= s_new_n;
      s_slot_r <= s_slot_n;
      d_ok_r   <= d_ok_n;
      d_new_r  <= d_new_n;
      d_slot_r <= d_slot_n;
      res_status_r <= (s_ok_n && d_ok_n) ? ST_COUNTED : ST_FULL;
    end
    if (state_r == S_RDW) begin
      res_addr_r <= rd_addr;
      res_cnt_r  <= rd_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
      out_cnt_r    <= res_cnt_r;
      out_used_r   <= used_wide[6:0];
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = out_status_r;
  assign out_ch.slot_address_out = out_addr_r;
  assign out_ch.tx_packets_out   = out_cnt_r.tx_pkts;
  assign out_ch.rx_packets_out   = out_cnt_r.rx_pkts;
  assign out_ch.tx_octets_out    = out_cnt_r.tx_octets;
  assign out_ch.rx_octets_out    = out_cnt_r.rx_octets;
  assign out_ch.slots_in_use     = out_used_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(TABLE_SLOTS))
    else $error("fill count beyond table size");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    issue_r <= used_r)
    else $error("scan index beyond fill count");

  a_used_only_at_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    !scan_done |=> $stable(used_r))
    else $error("fill count moved outside scan end");

  a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
    scan_done |=> ({1'b0, used_r} <= {1'b0, $past(used_r)} + (CNT_W+1)'(2)))
    else $error("more than two slots allocated for one frame");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_READ_VALID)
    |-> (out_addr_r == '0) && (out_cnt_r == '0))
    else $error("slot fields not zero on non-read result");

endmodule
